[hdl/alle_pkg.sv]
// Shared types and constants of the array linked list engine.
package alle_pkg;

  localparam int IDX_W = 8;
  localparam int CAP   = 2 ** IDX_W;
  localparam int VAL_W = 32;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAP - 1);

  typedef enum logic [1:0] {
    ACT_INS_AFTER  = 2'd0,
    ACT_INS_BEFORE = 2'd1,
    ACT_DELETE     = 2'd2,
    ACT_FIND       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic             next_we;
    logic [IDX_W-1:0] next_addr;
    logic [IDX_W-1:0] next_data;
    logic             prev_we;
    logic [IDX_W-1:0] prev_addr;
    logic [IDX_W-1:0] prev_data;
    logic             used_we;
    logic [IDX_W-1:0] used_addr;
    logic             used_data;
    logic             val_we;
    logic [IDX_W-1:0] val_addr;
    logic [VAL_W-1:0] val_data;
  } wr_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
    logic             used;
    logic [VAL_W-1:0] val;
  } rd_data_t;

endpackage

[hdl/alle_store.sv]
// Slot store: next links, previous links, used flags and values in synchronous memories.
module alle_store (
  input  logic                        clk,
  input  logic [alle_pkg::IDX_W-1:0]  rd_addr,
  input  alle_pkg::wr_req_t           wr,
  output alle_pkg::rd_data_t          rd
);

  logic [alle_pkg::IDX_W-1:0] nxt_mem [alle_pkg::CAP];
  logic [alle_pkg::IDX_W-1:0] prv_mem [alle_pkg::CAP];
  logic                       use_mem [alle_pkg::CAP];
  logic [alle_pkg::VAL_W-1:0] val_mem [alle_pkg::CAP];

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      nxt_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prv_mem[wr.prev_addr] <= wr.prev_data;
    end
    if (wr.used_we) begin
      use_mem[wr.used_addr] <= wr.used_data;
    end
    if (wr.val_we) begin
      val_mem[wr.val_addr] <= wr.val_data;
    end
    rd.nxt  <= nxt_mem[rd_addr];
    rd.prv  <= prv_mem[rd_addr];
    rd.used <= use_mem[rd_addr];
    rd.val  <= val_mem[rd_addr];
  end

endmodule

[hdl/array_linked_list_engine_top.sv]
// Top level of the array linked list engine: request sequencer and result register.
// Keeps a doubly linked list of up to 255 values in a 256-slot store, slot 0 being the
// sentinel, and answers every request with one result. After reset the block initialises the
// link memories and takes no request meanwhile. The sequencer handles one request at a time,
// reading and writing the slot memories once a cycle: an insert checks the slot, reads its
// neighbour and the free head, then fills and links the new slot; a delete checks, unlinks
// and frees the slot; a rejected insert or delete ends at the check; a find walks the list,
// one element per cycle, bounded by the live count. A result waits in the output register,
// and the next request is taken as soon as the sequencer is idle again.
module array_linked_list_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [alle_pkg::IDX_W-1:0]  in_slot_index,
  input  logic [alle_pkg::VAL_W-1:0]  in_item_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [alle_pkg::IDX_W-1:0]  out_result_slot,
  output logic [alle_pkg::IDX_W-1:0]  out_live_count
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHK, S_INX, S_IFH, S_ILINK, S_DFREE, S_FHEAD, S_FWALK, S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  alle_pkg::action_t          act_r, act_nxt;
  logic [alle_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [alle_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [alle_pkg::IDX_W-1:0] pos_r, pos_nxt;
  logic [alle_pkg::IDX_W-1:0] nx_r, nx_nxt;
  logic [alle_pkg::IDX_W-1:0] cur_r, cur_nxt;
  logic [alle_pkg::IDX_W-1:0] steps_r, steps_nxt;
  logic [alle_pkg::IDX_W-1:0] fh_r, fh_nxt;
  logic [alle_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [alle_pkg::IDX_W-1:0] clr_r, clr_nxt;
  alle_pkg::status_t          res_status_r, res_status_nxt;
  logic [alle_pkg::IDX_W-1:0] res_slot_r, res_slot_nxt;
  logic                       out_valid_r, out_valid_nxt;
  alle_pkg::status_t          out_status_r, out_status_nxt;
  logic [alle_pkg::IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [alle_pkg::IDX_W-1:0] out_count_r, out_count_nxt;

  logic [alle_pkg::IDX_W-1:0] rd_addr;
  alle_pkg::wr_req_t          wr;
  alle_pkg::rd_data_t         rd;
  logic                       out_free;
  logic [alle_pkg::IDX_W:0]   steps_inc;

  alle_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign steps_inc = {1'b0, steps_r} + (alle_pkg::IDX_W + 1)'(1);
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    nx_nxt         = nx_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    fh_nxt         = fh_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    rd_addr        = '0;
    wr             = '0;

    case (state_r)
      S_INIT: begin
        wr.next_we   = 1'b1;
        wr.next_addr = clr_r;
        wr.next_data = (clr_r == '0 || clr_r == alle_pkg::LAST_SLOT) ?
                       '0 : clr_r + alle_pkg::IDX_W'(1);
        wr.prev_we   = 1'b1;
        wr.prev_addr = clr_r;
        wr.prev_data = (clr_r == '0) ? '0 : clr_r - alle_pkg::IDX_W'(1);
        wr.used_we   = 1'b1;
        wr.used_addr = clr_r;
        wr.used_data = 1'b0;
        clr_nxt      = clr_r + alle_pkg::IDX_W'(1);
        if (clr_r == alle_pkg::LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = alle_pkg::action_t'(in_action);
          idx_nxt = in_slot_index;
          val_nxt = in_item_value;
          if (alle_pkg::action_t'(in_action) == alle_pkg::ACT_FIND) begin
            rd_addr   = '0;
            state_nxt = S_FHEAD;
          end else begin
            rd_addr   = in_slot_index;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        res_slot_nxt = '0;
        if (act_r == alle_pkg::ACT_DELETE) begin
          if (idx_r == '0 || !rd.used) begin
            res_status_nxt = alle_pkg::ST_INVALID;
            state_nxt      = S_OUT;
          end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = rd.prv;
            wr.next_data = rd.nxt;
            wr.prev_we   = 1'b1;
            wr.prev_addr = rd.nxt;
            wr.prev_data = rd.prv;
            wr.used_we   = 1'b1;
            wr.used_addr = idx_r;
            wr.used_data = 1'b0;
            state_nxt    = S_DFREE;
          end
        end else if (idx_r != '0 && !rd.used) begin
          res_status_nxt = alle_pkg::ST_INVALID;
          state_nxt      = S_OUT;
        end else if (cnt_r >= alle_pkg::LAST_SLOT) begin
          res_status_nxt = alle_pkg::ST_FULL;
          state_nxt      = S_OUT;
        end else begin
          pos_nxt   = (act_r == alle_pkg::ACT_INS_BEFORE) ? rd.prv : idx_r;
          rd_addr   = pos_nxt;
          state_nxt = S_INX;
        end
      end
      S_INX: begin
        nx_nxt    = rd.nxt;
        rd_addr   = fh_r;
        state_nxt = S_IFH;
      end
      S_IFH: begin
        wr.next_we   = 1'b1;
        wr.next_addr = fh_r;
        wr.next_data = nx_r;
        wr.prev_we   = 1'b1;
        wr.prev_addr = fh_r;
        wr.prev_data = pos_r;
        wr.used_we   = 1'b1;
        wr.used_addr = fh_r;
        wr.used_data = 1'b1;
        wr.val_we    = 1'b1;
        wr.val_addr  = fh_r;
        wr.val_data  = val_r;
        fh_nxt       = rd.nxt;
        res_slot_nxt = fh_r;
        state_nxt    = S_ILINK;
      end
      S_ILINK: begin
        wr.prev_we     = 1'b1;
        wr.prev_addr   = nx_r;
        wr.prev_data   = res_slot_r;
        wr.next_we     = 1'b1;
        wr.next_addr   = pos_r;
        wr.next_data   = res_slot_r;
        cnt_nxt        = cnt_r + alle_pkg::IDX_W'(1);
        res_status_nxt = alle_pkg::ST_OK;
        state_nxt      = S_OUT;
      end
      S_DFREE: begin
        wr.next_we     = 1'b1;
        wr.next_addr   = idx_r;
        wr.next_data   = fh_r;
        wr.prev_we     = 1'b1;
        wr.prev_addr   = idx_r;
        wr.prev_data   = '0;
        fh_nxt         = idx_r;
        cnt_nxt        = cnt_r - alle_pkg::IDX_W'(1);
        res_status_nxt = alle_pkg::ST_OK;
        res_slot_nxt   = '0;
        state_nxt      = S_OUT;
      end
      S_FHEAD: begin
        cur_nxt   = rd.nxt;
        steps_nxt = '0;
        if (cnt_r == '0 || rd.nxt == '0) begin
          res_status_nxt = alle_pkg::ST_NOT_FOUND;
          res_slot_nxt   = '0;
          state_nxt      = S_OUT;
        end else begin
          rd_addr   = rd.nxt;
          state_nxt = S_FWALK;
        end
      end
      S_FWALK: begin
        if (rd.used && rd.val == val_r) begin
          res_status_nxt = alle_pkg::ST_OK;
          res_slot_nxt   = cur_r;
          state_nxt      = S_OUT;
        end else if (steps_inc >= {1'b0, cnt_r} || rd.nxt == '0) begin
          res_status_nxt = alle_pkg::ST_NOT_FOUND;
          res_slot_nxt   = '0;
          state_nxt      = S_OUT;
        end else begin
          steps_nxt = steps_inc[alle_pkg::IDX_W-1:0];
          cur_nxt   = rd.nxt;
          rd_addr   = rd.nxt;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      fh_r        <= alle_pkg::IDX_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fh_r        <= fh_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    nx_r         <= nx_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_live_count  = out_count_r;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHK || state_r == S_FHEAD))
    else $error("An accepted request did not start the sequencer.");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ILINK) |=> (cnt_r == alle_pkg::IDX_W'($past(cnt_r) + 1)))
    else $error("A completed insert did not raise the live count by one.");

  a_free_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r < alle_pkg::LAST_SLOT) |-> (fh_r != '0))
    else $error("The free list is empty although the store is not full.");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWALK) |-> (steps_r < cnt_r))
    else $error("The find walk ran past the live count.");
`endif

endmodule

[tb/tb_array_linked_list_engine_top.sv]
// Self-checking testbench for the array linked list engine: random and directed list requests.
`timescale 1ns / 100ps

typedef struct packed {
  alle_pkg::status_t           status;
  logic [alle_pkg::IDX_W-1:0]  slot;
  logic [alle_pkg::IDX_W-1:0]  live;
} list_result_t;

class list_tracker;
  logic [alle_pkg::IDX_W-1:0] succ [alle_pkg::CAP];
  logic [alle_pkg::IDX_W-1:0] pred [alle_pkg::CAP];
  logic [alle_pkg::VAL_W-1:0] val [alle_pkg::CAP];
  bit                         used [alle_pkg::CAP];
  logic [alle_pkg::IDX_W-1:0] free_head;
  int                         count;
  int                         mismatches;
  list_result_t               expected_results [$];

  function new();
    for (int i = 0; i < alle_pkg::CAP; i++) begin
      succ[i] = (i + 1 < alle_pkg::CAP) ? alle_pkg::IDX_W'(i + 1) : '0;
      pred[i] = (i > 0) ? alle_pkg::IDX_W'(i - 1) : '0;
      val[i]  = '0;
      used[i] = 1'b0;
    end
    succ[0]    = '0;
    free_head  = alle_pkg::IDX_W'(1);
    count      = 0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function logic [alle_pkg::IDX_W-1:0] pick_live_slot(bit allow_sentinel);
    logic [alle_pkg::IDX_W-1:0] live_slots [$];
    for (int i = 1; i < alle_pkg::CAP; i++) begin
      if (used[i]) live_slots.push_back(alle_pkg::IDX_W'(i));
    end
    if (live_slots.size() == 0 || (allow_sentinel && $urandom_range(5) == 0)) begin
      return '0;
    end
    return live_slots[$urandom_range(live_slots.size() - 1)];
  endfunction

  function list_result_t apply_request(alle_pkg::action_t act,
                                       logic [alle_pkg::IDX_W-1:0] idx,
                                       logic [alle_pkg::VAL_W-1:0] value);
    list_result_t res;
    logic [alle_pkg::IDX_W-1:0] pos;
    logic [alle_pkg::IDX_W-1:0] slot;
    logic [alle_pkg::IDX_W-1:0] nx;
    logic [alle_pkg::IDX_W-1:0] cur;
    res.status = alle_pkg::ST_OK;
    res.slot   = '0;
    case (act)
      alle_pkg::ACT_INS_AFTER, alle_pkg::ACT_INS_BEFORE: begin
        if (idx != 0 && !used[idx]) begin
          res.status = alle_pkg::ST_INVALID;
        end else if (count >= alle_pkg::CAP - 1) begin
          res.status = alle_pkg::ST_FULL;
        end else begin
          pos       = (act == alle_pkg::ACT_INS_BEFORE) ? pred[idx] : idx;
          slot      = free_head;
          nx        = succ[pos];
          free_head = succ[slot];
          val[slot]  = value;
          used[slot] = 1'b1;
          succ[slot] = nx;
          pred[slot] = pos;
          pred[nx]   = slot;
          succ[pos]  = slot;
          count++;
          res.slot = slot;
        end
      end
      alle_pkg::ACT_DELETE: begin
        if (idx == 0 || !used[idx]) begin
          res.status = alle_pkg::ST_INVALID;
        end else begin
          pos       = pred[idx];
          nx        = succ[idx];
          succ[pos] = nx;
          pred[nx]  = pos;
          used[idx] = 1'b0;
          succ[idx] = free_head;
          pred[idx] = '0;
          free_head = idx;
          count--;
        end
      end
      default: begin
        res.status = alle_pkg::ST_NOT_FOUND;
        cur = succ[0];
        for (int steps = 0; steps < count; steps++) begin
          if (cur == 0) break;
          if (used[cur] && val[cur] == value) begin
            res.status = alle_pkg::ST_OK;
            res.slot   = cur;
            break;
          end
          cur = succ[cur];
        end
      end
    endcase
    res.live = alle_pkg::IDX_W'(count);
    return res;
  endfunction

  function void note_request(alle_pkg::action_t act, logic [alle_pkg::IDX_W-1:0] idx,
                             logic [alle_pkg::VAL_W-1:0] value);
    expected_results.push_back(apply_request(act, idx, value));
  endfunction

  function void check_result(logic [1:0] status, logic [alle_pkg::IDX_W-1:0] slot,
                             logic [alle_pkg::IDX_W-1:0] live);
    list_result_t exp_res;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, status %0d slot %0d live %0d",
               $time, status, slot, live);
      mismatches++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (status !== exp_res.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp_res.status, status);
      mismatches++;
    end
    if (slot !== exp_res.slot) begin
      $display("%0t: result_slot mismatch, expected %0d, actual %0d", $time, exp_res.slot, slot);
      mismatches++;
    end
    if (live !== exp_res.live) begin
      $display("%0t: live_count mismatch, expected %0d, actual %0d", $time, exp_res.live, live);
      mismatches++;
    end
  endfunction
endclass

module tb_array_linked_list_engine_top;

  localparam int QUIET_LIMIT = 3000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_action = alle_pkg::ACT_FIND;
  logic [alle_pkg::IDX_W-1:0] in_slot_index = '0;
  logic [alle_pkg::VAL_W-1:0] in_item_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic [alle_pkg::IDX_W-1:0] out_result_slot;
  logic [alle_pkg::IDX_W-1:0] out_live_count;

  list_tracker lists = new();
  int          send_idle_pct = 25;
  int          recv_idle_pct = 25;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  array_linked_list_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_slot_index   (in_slot_index),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_live_count  (out_live_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lists.check_result(out_status, out_result_slot, out_live_count);
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 9) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(input alle_pkg::action_t act,
                              input logic [alle_pkg::IDX_W-1:0] idx,
                              input logic [alle_pkg::VAL_W-1:0] value);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_slot_index <= idx;
    in_item_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lists.note_request(act, idx, value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic random_request(input int ins_pct, input int del_pct);
    int                         roll;
    alle_pkg::action_t          act;
    logic [alle_pkg::IDX_W-1:0] idx;
    logic [alle_pkg::VAL_W-1:0] value;
    roll  = $urandom_range(99);
    value = $urandom;
    if (roll < ins_pct) begin
      act = $urandom_range(1) ? alle_pkg::ACT_INS_BEFORE : alle_pkg::ACT_INS_AFTER;
      idx = ($urandom_range(9) == 0) ? alle_pkg::IDX_W'($urandom_range(255)) :
                                       lists.pick_live_slot(1);
      if ($urandom_range(3) == 0) value = alle_pkg::VAL_W'($urandom_range(7));
    end else if (roll < ins_pct + del_pct) begin
      act = alle_pkg::ACT_DELETE;
      idx = ($urandom_range(7) == 0) ? alle_pkg::IDX_W'($urandom_range(255)) :
                                       lists.pick_live_slot(0);
    end else begin
      act = alle_pkg::ACT_FIND;
      idx = alle_pkg::IDX_W'($urandom_range(255));
      if ($urandom_range(1)) value = lists.val[lists.pick_live_slot(0)];
      else if ($urandom_range(1)) value = alle_pkg::VAL_W'($urandom_range(7));
    end
    send_request(act, idx, value);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lists.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [alle_pkg::IDX_W-1:0] old_head;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(alle_pkg::ACT_FIND, 8'hFF, 32'h0000_0000);
    send_request(alle_pkg::ACT_DELETE, 8'd0, 32'h0000_0000);
    send_request(alle_pkg::ACT_DELETE, 8'd200, 32'hFFFF_FFFF);
    send_request(alle_pkg::ACT_INS_AFTER, 8'd0, 32'h0000_0000);
    send_request(alle_pkg::ACT_INS_BEFORE, 8'd0, 32'hFFFF_FFFF);
    send_request(alle_pkg::ACT_INS_AFTER, 8'd0, 32'h1234_5678);
    send_request(alle_pkg::ACT_INS_BEFORE, lists.succ[0], 32'hA5A5_A5A5);
    send_request(alle_pkg::ACT_INS_AFTER, 8'd9, 32'h0000_0001);
    send_request(alle_pkg::ACT_INS_BEFORE, 8'd255, 32'h0000_0002);
    send_request(alle_pkg::ACT_INS_AFTER, lists.pred[0], 32'h0000_0000);
    send_request(alle_pkg::ACT_FIND, 8'h00, 32'h0000_0000);
    send_request(alle_pkg::ACT_FIND, 8'h80, 32'hFFFF_FFFF);
    send_request(alle_pkg::ACT_FIND, 8'h01, 32'h1234_5678);
    send_request(alle_pkg::ACT_FIND, 8'h7F, 32'h5A5A_5A5A);
    old_head = lists.succ[0];
    send_request(alle_pkg::ACT_DELETE, old_head, 32'h0000_0000);
    send_request(alle_pkg::ACT_DELETE, lists.pred[0], 32'h0000_0000);
    send_request(alle_pkg::ACT_DELETE, lists.succ[lists.succ[0]], 32'h0000_0000);
    send_request(alle_pkg::ACT_DELETE, old_head, 32'h0000_0000);
    send_request(alle_pkg::ACT_FIND, 8'hFF, 32'hA5A5_A5A5);
    send_request(alle_pkg::ACT_INS_AFTER, 8'd0, 32'h0000_0001);

    while (lists.count < alle_pkg::CAP - 1) random_request(90, 3);
    repeat (15) random_request(80, 5);
    wait_for_results();

    send_idle_pct = 40;
    recv_idle_pct = 15;
    repeat (100) random_request(10, 80);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 30;
    repeat (60) random_request(45, 35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (60) random_request(45, 35);
    in_valid <= 1'b0;

    @(posedge clk);
    while (lists.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lists.mismatches == 0 && lists.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
